// ===== hdl/branch_direction_predictor_suite_top_macros.svh =====
// Assertion macros for the branch direction predictor suite checker.
// No dependencies; included by the checker file only.
`ifndef BRANCH_DIRECTION_PREDICTOR_SUITE_TOP_MACROS_SVH
`define BRANCH_DIRECTION_PREDICTOR_SUITE_TOP_MACROS_SVH

// Property checked on every clock edge outside reset.
`define BDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define BDP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/bdp_pkg.sv =====
// Shared types and counter helpers for the branch direction predictor suite.
// No dependencies.
package bdp_pkg;

  // One result word, highest bit first.
  typedef struct packed {
    logic is_forward;
    logic tournament_pred;
    logic majority_pred;
    logic hybrid_pred;
    logic gsh_pred;
    logic global_pred;
    logic local_pred;
    logic bimodal_pred;
    logic backward_pred;
  } pred_t;

  localparam int PRED_W = $bits(pred_t);
  localparam int OUT_DATA_W = 16;
  localparam int IN_DATA_W = 72;

  // 2-bit saturating counter step
  function automatic logic [1:0] sat2(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up) begin
      if (c != 2'd3) r = c + 2'd1;
    end else begin
      if (c != 2'd0) r = c - 2'd1;
    end
    return r;
  endfunction

  // 3-bit saturating counter step
  function automatic logic [2:0] sat3(input logic [2:0] c, input logic up);
    logic [2:0] r;
    r = c;
    if (up) begin
      if (c != 3'd7) r = c + 3'd1;
    end else begin
      if (c != 3'd0) r = c - 3'd1;
    end
    return r;
  endfunction

endpackage

// ===== hdl/bdp_table.sv =====
// Synchronous 1R1W table, registered read, same-cycle write bypass.
// No dependencies.
module bdp_table #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] mem_q;
  logic [WIDTH-1:0] byp_data;
  logic             byp;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // read port; a write to the same entry in the read cycle wins
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      byp      <= wr_en && (wr_addr == rd_addr);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp ? byp_data : mem_q;

endmodule

// ===== hdl/bdp_out_fifo.sv =====
// Four-entry result queue that decouples the predictor pipeline from the sink.
// Depends on bdp_pkg.
module bdp_out_fifo import bdp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  pred_t       push_data,
  output logic [2:0]  count,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  pred_t      slots [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic       pop;

  assign pop = m_tvalid && m_tready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 2'd1;
      if (pop) rptr <= rptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

  assign m_tvalid = (count != 3'd0);
  assign m_tdata  = {(OUT_DATA_W - PRED_W)'(0), slots[rptr]};

endmodule

// ===== hdl/branch_direction_predictor_suite_top.sv =====
// Branch direction predictor suite: eight direction predictors in table memories.
// Depends on bdp_pkg, bdp_table, bdp_out_fifo.
//
//  channel | dir | fields (lsb up)
//  s_*     | in  | pc[31:0], taken[32], branch_target[64:33], zero pad to 72
//  m_*     | out | backward, bimodal, local, global, gshare, hybrid, majority,
//          |     | tournament, is_forward, zero pad to 16
//
// One word per cycle while s_tready is high; each word passes history read,
// counter read, predict and write back; its result is then offered on m_tvalid.
// The local history read feeding the local counter read sets the pipeline depth.
// After reset a clearing pass over every index below max(2^HISTORY_BITS,
// LOCAL_TABLE_ENTRIES) zeroes the tables, with s_tready low; after it, s_tready
// drops only when the four-entry result queue could overflow.
module branch_direction_predictor_suite_top import bdp_pkg::*; #(
  parameter int HISTORY_BITS = 9,
  parameter int LOCAL_TABLE_ENTRIES = 1024  // power of two
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // pc, taken, branch_target
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // nine prediction bits, see pred_t
);

  localparam int HB    = HISTORY_BITS;
  localparam int TBL_N = 1 << HB;
  localparam int L_W   = $clog2(LOCAL_TABLE_ENTRIES);
  localparam int CLR_N = (TBL_N > LOCAL_TABLE_ENTRIES) ? TBL_N : LOCAL_TABLE_ENTRIES;
  localparam int CLR_W = $clog2(CLR_N);
  localparam int GT_W  = 11;  // global 3b + chooser + three tournament 2b

  // clearing pass
  logic             clr;
  logic [CLR_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr     <= 1'b1;
      clr_idx <= '0;
    end else if (clr) begin
      if (clr_idx == CLR_W'(CLR_N - 1)) clr <= 1'b0;
      clr_idx <= clr_idx + CLR_W'(1);
    end
  end

  // input unpack and credit
  logic        acc;
  logic [31:0] in_pc;
  logic        in_taken;
  logic [31:0] in_tgt;
  logic [2:0]  fifo_cnt;
  logic        v1, v2;

  assign in_pc    = s_tdata[31:0];
  assign in_taken = s_tdata[32];
  assign in_tgt   = s_tdata[64:33];
  assign s_tready = !clr && ((fifo_cnt + 3'(v1) + 3'(v2)) < 3'd4);
  assign acc      = s_tvalid && s_tready;

  // global history and stage 1 registers
  logic [HB-1:0] gh, gh1;
  logic [31:0]   pc1, tgt1;
  logic          tk1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gh <= '0;
      v1 <= 1'b0;
    end else begin
      v1 <= acc;
      if (acc) gh <= {gh[HB-2:0], in_taken};
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pc1  <= in_pc;
      tgt1 <= in_tgt;
      tk1  <= in_taken;
      gh1  <= gh;
    end
  end

  // local history table: read at accept, written back in stage 1
  logic [HB-1:0]  lh1;
  logic [L_W-1:0] lh_waddr;
  logic [HB-1:0]  lh_wdata;

  assign lh_waddr = clr ? clr_idx[L_W-1:0] : pc1[L_W-1:0];
  assign lh_wdata = clr ? '0 : {lh1[HB-2:0], tk1};

  bdp_table #(.WIDTH(HB), .DEPTH(LOCAL_TABLE_ENTRIES)) u_lhist (
    .clk(clk), .rd_en(acc), .rd_addr(in_pc[L_W-1:0]), .rd_data(lh1),
    .wr_en(clr || v1), .wr_addr(lh_waddr), .wr_data(lh_wdata)
  );

  // stage 2 registers
  logic          tk2, fwd2;
  logic [HB-1:0] bi2, lh2, gh2, gsi2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      tk2  <= tk1;
      fwd2 <= (tgt1 >= pc1);
      bi2  <= pc1[HB-1:0];
      lh2  <= lh1;
      gh2  <= gh1;
      gsi2 <= gh1 ^ pc1[HB-1:0];
    end
  end

  // counter tables: read in stage 1, written back in stage 2
  logic [1:0]      bim_rd, loc_rd, bim_wd, loc_wd;
  logic [2:0]      gsh_rd, gsh_wd;
  logic [GT_W-1:0] gt_rd, gt_wd;
  logic            cwe;
  logic [HB-1:0]   ca;

  assign cwe = clr || v2;
  assign ca  = clr_idx[HB-1:0];

  bdp_table #(.WIDTH(2), .DEPTH(TBL_N)) u_bim (
    .clk(clk), .rd_en(v1), .rd_addr(pc1[HB-1:0]), .rd_data(bim_rd),
    .wr_en(cwe), .wr_addr(clr ? ca : bi2), .wr_data(clr ? 2'd0 : bim_wd)
  );

  bdp_table #(.WIDTH(2), .DEPTH(TBL_N)) u_loc (
    .clk(clk), .rd_en(v1), .rd_addr(lh1), .rd_data(loc_rd),
    .wr_en(cwe), .wr_addr(clr ? ca : lh2), .wr_data(clr ? 2'd0 : loc_wd)
  );

  bdp_table #(.WIDTH(3), .DEPTH(TBL_N)) u_gsh (
    .clk(clk), .rd_en(v1), .rd_addr(gh1 ^ pc1[HB-1:0]), .rd_data(gsh_rd),
    .wr_en(cwe), .wr_addr(clr ? ca : gsi2), .wr_data(clr ? 3'd0 : gsh_wd)
  );

  // global-history indexed row: {lg_gs, l_gs, l_g, chooser, global}
  bdp_table #(.WIDTH(GT_W), .DEPTH(TBL_N)) u_grow (
    .clk(clk), .rd_en(v1), .rd_addr(gh1), .rd_data(gt_rd),
    .wr_en(cwe), .wr_addr(clr ? ca : gh2), .wr_data(clr ? GT_W'(0) : gt_wd)
  );

  // predictions and training
  pred_t      pred;
  logic [2:0] glb_c;
  logic [1:0] cho_c, tlg_c, tls_c, tgs_c;
  logic       p_loc, p_glb, p_gsh, use_glb, use_gsh;

  assign glb_c = gt_rd[2:0];
  assign cho_c = gt_rd[4:3];
  assign tlg_c = gt_rd[6:5];
  assign tls_c = gt_rd[8:7];
  assign tgs_c = gt_rd[10:9];

  always_comb begin
    p_loc   = loc_rd[1];
    p_glb   = glb_c[2];
    p_gsh   = gsh_rd[2];
    use_glb = tlg_c[1];
    use_gsh = use_glb ? tgs_c[1] : tls_c[1];

    pred.backward_pred   = !fwd2;
    pred.bimodal_pred    = bim_rd[1];
    pred.local_pred      = p_loc;
    pred.global_pred     = p_glb;
    pred.gsh_pred        = p_gsh;
    pred.hybrid_pred     = cho_c[1] ? p_glb : p_loc;
    pred.majority_pred   = (p_loc & p_glb) | (p_loc & p_gsh) | (p_glb & p_gsh);
    pred.tournament_pred = use_gsh ? p_gsh : (use_glb ? p_glb : p_loc);
    pred.is_forward      = fwd2;

    bim_wd = sat2(bim_rd, tk2);
    loc_wd = sat2(loc_rd, tk2);
    gsh_wd = sat3(gsh_rd, tk2);
    gt_wd  = gt_rd;
    gt_wd[2:0] = sat3(glb_c, tk2);
    // chooser-style counters move only on disagreement
    if (p_glb != p_loc) begin
      gt_wd[4:3] = sat2(cho_c, p_glb == tk2);
      gt_wd[6:5] = sat2(tlg_c, p_glb == tk2);
    end
    if (p_loc != p_gsh) gt_wd[8:7]  = sat2(tls_c, p_gsh == tk2);
    if (p_glb != p_gsh) gt_wd[10:9] = sat2(tgs_c, p_gsh == tk2);
  end

  // result queue
  bdp_out_fifo u_fifo (
    .clk(clk), .rst(rst), .push(v2), .push_data(pred), .count(fifo_cnt),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

endmodule

// ===== hdl/bdp_checker.sv =====
// Port-level checks for the branch direction predictor suite, bound to the top.
// Depends on bdp_pkg and branch_direction_predictor_suite_top_macros.svh.
`include "branch_direction_predictor_suite_top_macros.svh"

module bdp_port_checks import bdp_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // held word stays offered
  `BDP_ASSERT(a_hold_valid, (m_tvalid && !m_tready |=> m_tvalid), "result word dropped")
  // backward and forward bits are complements
  `BDP_ASSERT(a_dir_bits, (m_tvalid |-> (m_tdata[0] != m_tdata[8])), "direction bits agree")
  // no input taken right after reset while the tables clear
  `BDP_ASSERT_ALWAYS(a_clear_busy, ($past(rst) && !rst |-> !s_tready), "input taken during clear")
  // queue is empty right after reset
  `BDP_ASSERT_ALWAYS(a_rst_empty, ($past(rst) && !rst |-> !m_tvalid), "result after reset")

endmodule

bind branch_direction_predictor_suite_top bdp_port_checks u_bdp_port_checks (.*);
